FILE: rtl/core/adwd_pkg.sv
// Package for the ASCII date to weekday core: request types, status codes,
// character codes and the calendar helper functions. No dependencies.
package adwd_pkg;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [13:0] ACC_MAX  = 14'd9999;
  localparam logic [13:0] YEAR_MIN = 14'd1901;
  localparam logic [13:0] YEAR_MAX = 14'd2099;

  localparam logic [1:0] FIELD_DAY   = 2'd0;
  localparam logic [1:0] FIELD_MONTH = 2'd1;
  localparam logic [1:0] FIELD_YEAR  = 2'd2;
  localparam logic [1:0] FIELD_DONE  = 2'd3;

  localparam logic [2:0] ST_VALID    = 3'd0;
  localparam logic [2:0] ST_BADCHAR  = 3'd1;
  localparam logic [2:0] ST_BADYEAR  = 3'd2;
  localparam logic [2:0] ST_BADMONTH = 3'd3;
  localparam logic [2:0] ST_BADDAY   = 3'd4;

  typedef struct packed {
    logic        bad_char;
    logic [13:0] year;
    logic [13:0] month;
    logic [13:0] day;
  } adwd_job_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] base;
    logic [8:0]  moff;
  } adwd_part_t;

  function automatic logic [13:0] acc_digit(input logic [13:0] acc, input logic [3:0] digit);
    logic [17:0] v;
    v = 18'(acc) * 18'd10 + 18'(digit);
    return (v > 18'(ACC_MAX)) ? ACC_MAX : v[13:0];
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd2:                       r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:         r = 5'd31;
      default:                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Eight is one modulo seven, so octal digits can be summed.
  function automatic logic [2:0] mod7(input logic [16:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
       + 6'(v[16:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

FILE: rtl/core/adwd_front.sv
// Front end: takes characters, accumulates the day, month and year fields
// and issues one request per newline or invalid character. Uses adwd_pkg.
module adwd_front import adwd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       q_full,
  output logic       q_push,
  output adwd_job_t  q_job
);

  logic [13:0] day_r, day_nxt;
  logic [13:0] month_r, month_nxt;
  logic [13:0] year_r, year_nxt;
  logic [1:0]  field_r, field_nxt;
  logic        accept;
  logic        is_digit;
  logic        is_dash;
  logic [3:0]  digit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign is_dash  = (in_char_code == CH_DASH);
  assign digit    = 4'(in_char_code - CH_ZERO);

  assign q_push        = accept && !is_digit && !is_dash;
  assign q_job.bad_char = (in_char_code != CH_NEWLINE);
  assign q_job.year    = year_r;
  assign q_job.month   = month_r;
  assign q_job.day     = day_r;

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    field_nxt = field_r;
    if (accept) begin
      if (is_digit) begin
        unique case (field_r)
          FIELD_DAY:   day_nxt   = acc_digit(day_r, digit);
          FIELD_MONTH: month_nxt = acc_digit(month_r, digit);
          FIELD_YEAR:  year_nxt  = acc_digit(year_r, digit);
          default:     ;
        endcase
      end else if (is_dash) begin
        if (field_r != FIELD_DONE) begin
          field_nxt = field_r + 2'd1;
        end
      end else begin
        day_nxt   = '0;
        month_nxt = '0;
        year_nxt  = '0;
        field_nxt = FIELD_DAY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= '0;
      month_r <= '0;
      year_r  <= '0;
      field_r <= FIELD_DAY;
    end else begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      field_r <= field_nxt;
    end
  end

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (day_r <= ACC_MAX) && (month_r <= ACC_MAX) && (year_r <= ACC_MAX))
    else $error("field accumulator above saturation limit");
  a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (field_r == FIELD_DAY) && (day_r == '0) && (year_r == '0))
    else $error("state not cleared after request");
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request issued into a full queue");

endmodule

FILE: rtl/core/adwd_queue.sv
// Short request queue between the front and back ends.
// Uses adwd_pkg for the request type.
module adwd_queue import adwd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  adwd_job_t push_job,
  input  logic      pop,
  output adwd_job_t head_job,
  output logic      full,
  output logic      not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  adwd_job_t       slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not follow a lone push");

endmodule

FILE: rtl/core/adwd_back.sv
// Back end: checks each queued date and computes the day count and weekday
// in two registered stages. Uses adwd_pkg for types and calendar functions.
module adwd_back import adwd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  adwd_job_t   q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_weekday,
  output logic [16:0] out_day_count
);

  logic        s1_valid_r;
  adwd_part_t  s1_r;
  adwd_part_t  s1_nxt;
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [2:0]  weekday_r;
  logic [16:0] count_r;
  logic        out_take;
  logic        s1_take;
  logic        year_ok;
  logic        month_ok;
  logic        day_ok;
  logic        leap;
  logic [3:0]  m4;
  logic [13:0] ydiff;
  logic [7:0]  yoff;
  logic [16:0] count_sum;

  assign out_take = !out_valid_r || !out_stall;
  assign s1_take  = !s1_valid_r || out_take;
  assign q_pop    = q_not_empty && s1_take;

  always_comb begin
    year_ok  = (q_head.year >= YEAR_MIN) && (q_head.year <= YEAR_MAX);
    month_ok = (q_head.month >= 14'd1) && (q_head.month <= 14'd12);
    leap     = (q_head.year[1:0] == 2'd0);
    m4       = q_head.month[3:0];
    day_ok   = (q_head.day != '0) && (q_head.day <= 14'(month_len(m4, leap)));
    ydiff    = q_head.year - YEAR_MIN;
    yoff     = ydiff[7:0];
    s1_nxt.base = '0;
    s1_nxt.moff = '0;
    if (q_head.bad_char) begin
      s1_nxt.status = ST_BADCHAR;
    end else if (!year_ok) begin
      s1_nxt.status = ST_BADYEAR;
    end else if (!month_ok) begin
      s1_nxt.status = ST_BADMONTH;
    end else if (!day_ok) begin
      s1_nxt.status = ST_BADDAY;
    end else begin
      s1_nxt.status = ST_VALID;
      s1_nxt.base   = 17'(yoff) * 17'd365 + 17'(yoff[7:2]);
      s1_nxt.moff   = days_before(m4) + 9'((leap && (m4 > 4'd2)) ? 1 : 0)
                    + 9'(q_head.day[4:0] - 5'd1);
    end
  end

  assign count_sum = s1_r.base + 17'(s1_r.moff);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= s1_nxt;
    end
    if (s1_valid_r && out_take) begin
      status_r  <= s1_r.status;
      weekday_r <= mod7(count_sum);
      count_r   <= count_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_r <= q_pop;
      end
      if (out_take) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_weekday   = weekday_r;
  assign out_day_count = count_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_VALID)) |-> (weekday_r == '0) && (count_r == '0))
    else $error("non-valid result carries a nonzero count or weekday");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r <= ST_BADDAY) && (weekday_r <= 3'd6))
    else $error("result code out of range");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r <= 17'd73048))
    else $error("day count beyond the supported range");

endmodule

FILE: rtl/core/ascii_date_to_weekday_core.sv
// Top level of the ASCII date to weekday core: front end, request queue and
// back end. Depends on adwd_pkg, adwd_front, adwd_queue and adwd_back.
//
// The core takes one character per cycle on the in_ channel while in_stall is
// low and produces one result per newline or invalid character on the out_
// channel. A date is written day-month-year with dashes between the fields; a
// newline closes it. Requests pass through the queue, stage one and the output
// register; results can leave one per cycle while out_stall is low. Characters
// that cause no result are always taken while the request queue between front
// and back end (QUEUE_DEPTH entries) has room; when out_stall holds off the
// results, the queue fills and in_stall rises. Status 0 is a valid date with
// day_count counted from 1 January 1901 and weekday 0 meaning Tuesday.
module ascii_date_to_weekday_core import adwd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_weekday,
  output logic [16:0] out_day_count
);

  logic      q_full;
  logic      q_not_empty;
  logic      q_push;
  logic      q_pop;
  adwd_job_t push_job;
  adwd_job_t head_job;

  adwd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  adwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .head_job  (head_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  adwd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (head_job),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_weekday   (out_weekday),
    .out_day_count (out_day_count)
  );

endmodule

FILE: tb/ascii_date_to_weekday_checker.sv
`timescale 1ns / 100ps
// Checker for ascii_date_to_weekday_core: follows every accepted character,
// predicts the date results and compares them with the result channel.
// Depends on adwd_pkg.
module ascii_date_to_weekday_checker import adwd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [2:0]  out_weekday,
  input  logic [16:0] out_day_count,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          valid_dates
);

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  weekday;
    logic [16:0] day_count;
  } date_result_t;

  date_result_t results_due[$];
  logic [13:0] day_acc;
  logic [13:0] month_acc;
  logic [13:0] year_acc;
  logic [1:0]  field_sel;

  initial begin
    fail_count = 0;
    results_seen = 0;
    valid_dates = 0;
    pending = 0;
  end

  function automatic int days_in_month(input int m);
    case (m)
      2: return 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic logic [13:0] add_digit(input logic [13:0] acc, input logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c - CH_ZERO);
    return (v > int'(ACC_MAX)) ? ACC_MAX : 14'(v);
  endfunction

  // The year is checked first, then the month, then the day.
  function automatic date_result_t evaluate_date(input int d, input int m, input int y);
    date_result_t r;
    int limit;
    int count;
    bit leap;
    r = '0;
    leap = (y % 4) == 0;
    if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX)) begin
      r.status = ST_BADYEAR;
    end else if (m < 1 || m > 12) begin
      r.status = ST_BADMONTH;
    end else begin
      limit = days_in_month(m) + ((m == 2 && leap) ? 1 : 0);
      if (d < 1 || d > limit) begin
        r.status = ST_BADDAY;
      end else begin
        count = (y - int'(YEAR_MIN)) * 365 + (y - int'(YEAR_MIN)) / 4;
        for (int i = 1; i < m; i++) begin
          count += days_in_month(i);
        end
        if (m > 2 && leap) begin
          count++;
        end
        count += d - 1;
        r.status = ST_VALID;
        r.weekday = 3'(count % 7);
        r.day_count = 17'(count);
      end
    end
    return r;
  endfunction

  function automatic void clear_fields();
    day_acc = '0;
    month_acc = '0;
    year_acc = '0;
    field_sel = FIELD_DAY;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    date_result_t r;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      case (field_sel)
        FIELD_DAY: day_acc = add_digit(day_acc, c);
        FIELD_MONTH: month_acc = add_digit(month_acc, c);
        FIELD_YEAR: year_acc = add_digit(year_acc, c);
        default: ;
      endcase
    end else if (c == CH_DASH) begin
      if (field_sel != FIELD_DONE) begin
        field_sel = field_sel + 2'd1;
      end
    end else begin
      if (c == CH_NEWLINE) begin
        r = evaluate_date(int'(day_acc), int'(month_acc), int'(year_acc));
      end else begin
        r = '0;
        r.status = ST_BADCHAR;
      end
      results_due.push_back(r);
      clear_fields();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    date_result_t want;
    if (!rst_n) begin
      clear_fields();
      results_due.delete();
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        take_char(in_char_code);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result with status %0d arrived with none due",
                                    out_status));
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status is %0d, expected %0d", out_status,
                                      want.status));
          end
          if (out_weekday !== want.weekday) begin
            report_mismatch($sformatf("weekday is %0d, expected %0d", out_weekday,
                                      want.weekday));
          end
          if (out_day_count !== want.day_count) begin
            report_mismatch($sformatf("day_count is %0d, expected %0d", out_day_count,
                                      want.day_count));
          end
          if (want.status == ST_VALID) begin
            valid_dates++;
          end
        end
      end
      pending <= results_due.size();
    end
  end

endmodule

FILE: tb/ascii_date_to_weekday_core_tb.sv
`timescale 1ns / 100ps
// Top of the ascii_date_to_weekday_core testbench: clock, reset, character
// stimulus, result-side stalling and the verdict. Depends on adwd_pkg, the
// core and ascii_date_to_weekday_checker.
module ascii_date_to_weekday_core_tb;
  import adwd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [2:0]  out_weekday;
  logic [16:0] out_day_count;

  int fail_count;
  int pending;
  int results_seen;
  int valid_dates;
  int chars_sent;
  int held_cycles;
  bit calm;
  bit squeezed;
  logic squeeze_req;

  ascii_date_to_weekday_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_weekday(out_weekday),
    .out_day_count(out_day_count)
  );

  ascii_date_to_weekday_checker date_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_weekday(out_weekday),
    .out_day_count(out_day_count),
    .fail_count(fail_count),
    .pending(pending),
    .results_seen(results_seen),
    .valid_dates(valid_dates)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (in_valid && in_stall) begin
      held_cycles++;
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = (calm || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  function automatic string lead();
    string s;
    s = "";
    if ($urandom_range(0, 3) == 0) begin
      s = "0";
    end
    return s;
  endfunction

  function automatic string date_text(input int d, input int m, input int y);
    return $sformatf("%s%0d-%s%0d-%0d", lead(), d, lead(), m, y);
  endfunction

  function automatic string digit_run(input int n);
    string s;
    s = "";
    repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  // One pick per call: a well-formed date, a leap-year case, malformed text or noise.
  task automatic send_random_sequence();
    int pick;
    int d;
    int m;
    int y;
    int n;
    int cut;
    string s;
    pick = $urandom_range(0, 99);
    d = $urandom_range(1, 28);
    m = $urandom_range(1, 12);
    y = $urandom_range(1901, 2099);
    n = $urandom_range(5, 8);
    s = "";
    if ($urandom_range(0, 9) == 0) begin
      y = $urandom_range(0, 1) ? 1901 : 2099;
    end
    if (pick < 45) begin
      if ($urandom_range(0, 3) == 0) begin
        d = $urandom_range(29, 31);
      end
      s = {date_text(d, m, y), "\n"};
    end else if (pick < 52) begin
      y = 1904 + 4 * $urandom_range(0, 48);
      case ($urandom_range(0, 3))
        0: s = date_text(29, 2, y);
        1: s = date_text(1, 3, y);
        2: s = date_text(29, 2, y + $urandom_range(1, 3));
        default: s = date_text(31, 12, y);
      endcase
      s = {s, "\n"};
    end else if (pick < 58) begin
      case ($urandom_range(0, 3))
        0: y = 1900;
        1: y = 2100;
        2: y = $urandom_range(0, 9999);
        default: y = 0;
      endcase
      s = {date_text(d, m, y), "\n"};
    end else if (pick < 63) begin
      m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
      s = {date_text(d, m, y), "\n"};
    end else if (pick < 68) begin
      d = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
      s = {date_text(d, m, y), "\n"};
    end else if (pick < 73) begin
      case ($urandom_range(0, 2))
        0: s = $sformatf("%s-%0d-%0d\n", digit_run(n), m, y);
        1: s = $sformatf("%0d-%s-%0d\n", d, digit_run(n), y);
        default: s = $sformatf("%0d-%0d-%s\n", d, m, digit_run(n));
      endcase
    end else if (pick < 78) begin
      if ($urandom_range(0, 3) == 0) begin
        s = $sformatf("%0d--%0d-%0d\n", d, m, y);
      end else begin
        s = {date_text(d, m, y), "-", digit_run($urandom_range(0, 3)), "--",
             digit_run($urandom_range(0, 2)), "\n"};
      end
    end else if (pick < 83) begin
      case ($urandom_range(0, 3))
        0: s = "\n";
        1: s = $sformatf("%0d\n", d);
        2: s = $sformatf("%0d-%0d\n", d, m);
        default: s = $sformatf("%0d-%0d-\n", d, m);
      endcase
    end else if (pick < 92) begin
      s = date_text(d, m, y);
      cut = $urandom_range(0, s.len() - 1);
      send_text(s.substr(0, cut));
      send_char(8'($urandom_range(0, 255)));
      s = "";
    end else begin
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
    end
    if (s.len() > 0) begin
      send_text(s);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_code <= '0;
    squeeze_req <= 1'b0;
    calm = 1'b0;
    squeezed = 1'b0;
    chars_sent = 0;
    held_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_NEWLINE);
    send_text("1-1-1901\n");
    send_text("31-12-2099\n");

    while (chars_sent < 1200) begin
      if ($urandom_range(0, 19) == 0) begin
        calm = !calm;
      end
      // The result side stops for a long stretch while requests keep coming.
      if (!squeezed && chars_sent >= 500) begin
        squeezed = 1'b1;
        calm = 1'b1;
        squeeze_req <= 1'b1;
        repeat (30) begin
          send_char($urandom_range(0, 1) ? CH_NEWLINE : 8'($urandom_range(0, 255)));
        end
        calm = 1'b0;
      end
      send_random_sequence();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters and checked %0d date results, %0d of them valid dates.",
             chars_sent, results_seen, valid_dates);
    $display("The input was held off for %0d cycles while results backed up.",
             held_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : result_side
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (squeeze_req) begin
        hold = 150;
        squeeze_req <= 1'b0;
      end else begin
        hold = (calm || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 17);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

endmodule

FILE: filelist.f
rtl/core/adwd_pkg.sv
rtl/core/adwd_front.sv
rtl/core/adwd_queue.sv
rtl/core/adwd_back.sv
rtl/core/ascii_date_to_weekday_core.sv
tb/ascii_date_to_weekday_checker.sv
tb/ascii_date_to_weekday_core_tb.sv
